[src/mts_pkg.sv]
// Shared constants and codes for the memory test sequencer.
package mts_pkg;

    // Data path widths.
    localparam int DATA_WIDTH = 32;
    localparam int BIT_POS_W  = $clog2(DATA_WIDTH);
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 31;
    localparam int ACCESS_W   = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Request operation codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Access codes on the result channel.
    localparam logic [ACCESS_W-1:0] ACC_NONE   = 2'd0;
    localparam logic [ACCESS_W-1:0] ACC_WRITE  = 2'd1;
    localparam logic [ACCESS_W-1:0] ACC_READ   = 2'd2;
    localparam logic [ACCESS_W-1:0] ACC_FINISH = 2'd3;

    // Configuration register indexes (word address paddr[3:2]).
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_WORD_COUNT   = 2'd1;
    localparam logic [1:0] REG_CONTINUOUS   = 2'd2;

endpackage

[src/mts_if.sv]
// Handshake interfaces for the request and result channels.
interface mts_req_if
    import mts_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        op;
    logic [WORD_W-1:0] read_data;

    modport source (output valid, output op, output read_data, input ready);
    modport sink   (input valid, input op, input read_data, output ready);
endinterface

interface mts_rsp_if
    import mts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACCESS_W-1:0] access;
    logic [WORD_W-1:0]   address;
    logic [WORD_W-1:0]   write_data;
    logic                mismatch;
    logic [WORD_W-1:0]   checked_address;
    logic [WORD_W-1:0]   expected_value;
    logic [WORD_W-1:0]   error_count;
    logic                passed;

    modport source (
        output valid, output access, output address, output write_data,
        output mismatch, output checked_address, output expected_value,
        output error_count, output passed, input ready
    );
    modport sink (
        input valid, input access, input address, input write_data,
        input mismatch, input checked_address, input expected_value,
        input error_count, input passed, output ready
    );
endinterface

[src/memory_test_sequencer_unit.sv]
// Memory test sequencer: walking-ones and address-in-address self-test engine.
//
//  Channel   Direction  Handshake                     Payload
//  i_req     in         valid/ready                   op, read_data
//  o_rsp     out        valid/ready                   access, address, write_data, mismatch,
//                                                     checked_address, expected_value,
//                                                     error_count, passed
//  APB       in/out     psel/penable/pwrite, pready=1 base_address, word_count, continuous
//
// One request transaction is taken per cycle; its result appears in the output
// register on the next cycle. The sequencer state and the result register are
// both loaded at the accepting edge, so throughput is one transaction per cycle.
// A result that is not taken stalls the request side only when the output
// register is full and not being drained. Synchronous reset clears the sequencer
// state, the configuration and the output valid.
module memory_test_sequencer_unit
    import mts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mts_req_if.sink            i_req,
    mts_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WALK_WR,
        PH_WALK_RD,
        PH_ADDR_WR,
        PH_ADDR_RD,
        PH_DONE
    } t_phase;

    // Configuration registers.
    logic [WORD_W-1:0]  r_base_address;
    logic [COUNT_W-1:0] r_word_count;
    logic               r_continuous;

    // Sequencer state.
    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_word_idx, n_word_idx;
    logic [BIT_POS_W-1:0] r_bit_pos, n_bit_pos;
    logic [WORD_W-1:0]    r_errors, n_errors;

    // Result register.
    logic                r_out_valid;
    logic [ACCESS_W-1:0] r_access, n_access;
    logic [WORD_W-1:0]   r_address, n_address;
    logic [WORD_W-1:0]   r_write_data, n_write_data;
    logic                r_mismatch, n_mismatch;
    logic [WORD_W-1:0]   r_checked_address, n_checked_address;
    logic [WORD_W-1:0]   r_expected_value, n_expected_value;
    logic                r_passed, n_passed;

    logic               accept;
    logic               cfg_write;
    logic [WORD_W-1:0]  aligned_base;
    logic [WORD_W-1:0]  cur_addr;
    logic [WORD_W-1:0]  cur_walk;
    logic [WORD_W-1:0]  next_addr;
    logic [WORD_W-1:0]  next_walk;
    logic [WORD_W-1:0]  expected;
    logic               last_word;
    logic               last_bit;

    // Configuration port: writes in the access phase, reads always available.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
            r_word_count   <= '0;
            r_continuous   <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_BASE_ADDRESS: r_base_address <= pwdata;
                REG_WORD_COUNT:   r_word_count   <= pwdata[COUNT_W-1:0];
                REG_CONTINUOUS:   r_continuous   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE_ADDRESS: prdata = r_base_address;
            REG_WORD_COUNT:   prdata = {{(PDATA_W-COUNT_W){1'b0}}, r_word_count};
            REG_CONTINUOUS:   prdata = {{(PDATA_W-1){1'b0}}, r_continuous};
            default:          prdata = '0;
        endcase
    end

    // A new request is taken whenever the result register is free or draining.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // Address and walking pattern of the word currently addressed.
    assign aligned_base = {r_base_address[WORD_W-1:2], 2'b00};
    assign cur_addr     = aligned_base + {r_word_idx[WORD_W-3:0], 2'b00};
    assign cur_walk     = WORD_W'(64'(1) << r_bit_pos);
    assign expected     = (r_phase == PH_WALK_RD) ? cur_walk : cur_addr;
    assign last_word    = ({1'b0, r_word_idx} + WORD_W'(1)) >= {1'b0, r_word_count};
    assign last_bit     = (r_bit_pos == BIT_POS_W'(DATA_WIDTH - 1));

    // Address and pattern of the access about to be issued.
    assign next_addr = aligned_base + {n_word_idx[WORD_W-3:0], 2'b00};
    assign next_walk = WORD_W'(64'(1) << n_bit_pos);

    // Check the returned read and step the sequence.
    always_comb begin
        n_phase           = r_phase;
        n_word_idx        = r_word_idx;
        n_bit_pos         = r_bit_pos;
        n_errors          = r_errors;
        n_mismatch        = 1'b0;
        n_checked_address = '0;
        n_expected_value  = '0;

        if (i_req.op == OP_START) begin
            n_errors   = '0;
            n_word_idx = '0;
            n_bit_pos  = '0;
            n_phase    = (r_word_count == '0) ? PH_DONE : PH_WALK_WR;
        end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
            if (r_phase == PH_WALK_RD || r_phase == PH_ADDR_RD) begin
                n_checked_address = cur_addr;
                n_expected_value  = expected;
                if (i_req.read_data != expected) begin
                    n_mismatch = 1'b1;
                    if (r_errors != '1) begin
                        n_errors = r_errors + WORD_W'(1);
                    end
                end
            end
            unique case (r_phase)
                PH_WALK_WR: n_phase = PH_WALK_RD;
                PH_WALK_RD: begin
                    if (!last_bit) begin
                        n_bit_pos = r_bit_pos + BIT_POS_W'(1);
                        n_phase   = PH_WALK_WR;
                    end else begin
                        n_bit_pos = '0;
                        if (last_word) begin
                            n_word_idx = '0;
                            n_phase    = PH_ADDR_WR;
                        end else begin
                            n_word_idx = r_word_idx + COUNT_W'(1);
                            n_phase    = PH_WALK_WR;
                        end
                    end
                end
                PH_ADDR_WR: begin
                    if (last_word) begin
                        n_word_idx = '0;
                        n_phase    = PH_ADDR_RD;
                    end else begin
                        n_word_idx = r_word_idx + COUNT_W'(1);
                    end
                end
                PH_ADDR_RD: begin
                    if (!last_word) begin
                        n_word_idx = r_word_idx + COUNT_W'(1);
                    end else if (r_continuous && n_errors == '0 && r_word_count != '0) begin
                        n_word_idx = '0;
                        n_bit_pos  = '0;
                        n_phase    = PH_WALK_WR;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Describe the access for the new phase.
    always_comb begin
        n_access     = ACC_NONE;
        n_address    = '0;
        n_write_data = '0;
        n_passed     = 1'b0;
        if (i_req.op == OP_START || (r_phase != PH_IDLE && r_phase != PH_DONE)) begin
            unique case (n_phase)
                PH_WALK_WR: begin
                    n_access     = ACC_WRITE;
                    n_address    = next_addr;
                    n_write_data = next_walk;
                end
                PH_WALK_RD, PH_ADDR_RD: begin
                    n_access  = ACC_READ;
                    n_address = next_addr;
                end
                PH_ADDR_WR: begin
                    n_access     = ACC_WRITE;
                    n_address    = next_addr;
                    n_write_data = next_addr;
                end
                default: begin
                    n_access = ACC_FINISH;
                    n_passed = (n_errors == '0);
                end
            endcase
        end
    end

    // Sequencer state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_word_idx <= '0;
            r_bit_pos  <= '0;
            r_errors   <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_word_idx <= n_word_idx;
            r_bit_pos  <= n_bit_pos;
            r_errors   <= n_errors;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_access          <= n_access;
            r_address         <= n_address;
            r_write_data      <= n_write_data;
            r_mismatch        <= n_mismatch;
            r_checked_address <= n_checked_address;
            r_expected_value  <= n_expected_value;
            r_passed          <= n_passed;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.access          = r_access;
    assign o_rsp.address         = r_address;
    assign o_rsp.write_data      = r_write_data;
    assign o_rsp.mismatch        = r_mismatch;
    assign o_rsp.checked_address = r_checked_address;
    assign o_rsp.expected_value  = r_expected_value;
    assign o_rsp.error_count     = r_errors;
    assign o_rsp.passed          = r_passed;

endmodule

[src/mts_checker.sv]
// Port-level checker for the memory test sequencer and its bind statement.
module mts_checker
    import mts_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [ACCESS_W-1:0] i_rsp_access,
    input logic [WORD_W-1:0]   i_rsp_address,
    input logic                i_rsp_passed
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // Every accepted request produces a result on the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request without result");

    // A stalled full result register blocks new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request taken while result stalled");

    // Pass status is only reported with a finished access.
    a_passed_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_passed |-> i_rsp_access == ACC_FINISH)
        else $error("passed without finished access");

    // A stalled result holds its address.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_address))
        else $error("stalled result changed");

endmodule

bind memory_test_sequencer_unit mts_checker u_mts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_access  (o_rsp.access),
    .i_rsp_address (o_rsp.address),
    .i_rsp_passed  (o_rsp.passed)
);

[sim/mts_tb_pkg.sv]
// Scoreboard class that predicts and checks the memory test sequencer results.
`timescale 1ns / 100ps

package mts_tb_pkg;
    import mts_pkg::*;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic [ACCESS_W-1:0] access;
        logic [WORD_W-1:0]   address;
        logic [WORD_W-1:0]   write_data;
        logic                mismatch;
        logic [WORD_W-1:0]   checked_address;
        logic [WORD_W-1:0]   expected_value;
        logic [WORD_W-1:0]   error_count;
        logic                passed;
    } t_access_result;

    // Kind of the access that the sequencer issued last.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WALK_WR,
        SEQ_WALK_RD,
        SEQ_ADDR_WR,
        SEQ_ADDR_RD,
        SEQ_DONE
    } t_seq_phase;

    class mts_scoreboard;
        // Configuration copy.
        logic [WORD_W-1:0]  region_base;
        logic [COUNT_W-1:0] region_words;
        logic               repeat_mode;

        // Sequencer state copy.
        t_seq_phase          phase;
        logic [COUNT_W-1:0]  word_index;
        logic [BIT_POS_W-1:0] bit_position;
        logic                awaiting_read;
        logic [WORD_W-1:0]   error_total;

        t_access_result expected_accesses[$];

        // Run statistics and failure count.
        int unsigned failures;
        int unsigned accepted;
        int unsigned writes_seen;
        int unsigned reads_seen;
        int unsigned finishes_seen;
        int unsigned mismatches_seen;

        function new();
            region_base   = '0;
            region_words  = '0;
            repeat_mode   = 1'b0;
            phase         = SEQ_IDLE;
            word_index    = '0;
            bit_position  = '0;
            awaiting_read = 1'b0;
            error_total   = '0;
        endfunction

        function void set_register(logic [1:0] index, logic [PDATA_W-1:0] value);
            case (index)
                REG_BASE_ADDRESS: region_base = value;
                REG_WORD_COUNT:   region_words = value[COUNT_W-1:0];
                REG_CONTINUOUS:   repeat_mode = value[0];
                default: ;
            endcase
        endfunction

        function logic running();
            return (phase != SEQ_IDLE) && (phase != SEQ_DONE);
        endfunction

        function int unsigned outstanding();
            return expected_accesses.size();
        endfunction

        function logic [WORD_W-1:0] word_address();
            return {region_base[WORD_W-1:2], 2'b00} + {word_index[COUNT_W-2:0], 2'b00};
        endfunction

        function logic [WORD_W-1:0] walking_pattern();
            return 32'h1 << bit_position;
        endfunction

        // Value the pending read should return; meaningful while a read is awaited.
        function logic [WORD_W-1:0] read_expectation();
            return (phase == SEQ_WALK_RD) ? walking_pattern() : word_address();
        endfunction

        function void begin_pass();
            word_index   = '0;
            bit_position = '0;
            phase        = (region_words == '0) ? SEQ_DONE : SEQ_WALK_WR;
        endfunction

        // Fill in the access that the current state describes.
        function void issue_access(ref t_access_result r);
            case (phase)
                SEQ_WALK_WR: begin
                    r.access      = ACC_WRITE;
                    r.address     = word_address();
                    r.write_data  = walking_pattern();
                    awaiting_read = 1'b0;
                end
                SEQ_WALK_RD, SEQ_ADDR_RD: begin
                    r.access      = ACC_READ;
                    r.address     = word_address();
                    awaiting_read = 1'b1;
                end
                SEQ_ADDR_WR: begin
                    r.access      = ACC_WRITE;
                    r.address     = word_address();
                    r.write_data  = word_address();
                    awaiting_read = 1'b0;
                end
                default: begin
                    r.access      = ACC_FINISH;
                    r.passed      = (error_total == '0);
                    awaiting_read = 1'b0;
                end
            endcase
        endfunction

        // Move to the next access of the test.
        function void step_forward();
            logic [31:0] next_index;
            logic        last_word;
            next_index = 32'(word_index) + 32'd1;
            last_word  = next_index >= 32'(region_words);
            case (phase)
                SEQ_WALK_WR: phase = SEQ_WALK_RD;
                SEQ_WALK_RD: begin
                    if (32'(bit_position) + 32'd1 < 32'(DATA_WIDTH)) begin
                        bit_position = bit_position + 1'b1;
                        phase = SEQ_WALK_WR;
                    end else begin
                        bit_position = '0;
                        if (last_word) begin
                            word_index = '0;
                            phase = SEQ_ADDR_WR;
                        end else begin
                            word_index = next_index[COUNT_W-1:0];
                            phase = SEQ_WALK_WR;
                        end
                    end
                end
                SEQ_ADDR_WR: begin
                    if (last_word) begin
                        word_index = '0;
                        phase = SEQ_ADDR_RD;
                    end else begin
                        word_index = next_index[COUNT_W-1:0];
                    end
                end
                SEQ_ADDR_RD: begin
                    if (!last_word) begin
                        word_index = next_index[COUNT_W-1:0];
                    end else if (repeat_mode && error_total == '0 && region_words != '0) begin
                        begin_pass();
                    end else begin
                        phase = SEQ_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        // Predict the result of one accepted request transaction.
        function void note_request(logic op, logic [WORD_W-1:0] read_data);
            t_access_result r;
            r = '0;
            accepted++;
            if (op == OP_START) begin
                error_total   = '0;
                awaiting_read = 1'b0;
                begin_pass();
                issue_access(r);
            end else if (!running()) begin
                r.access = ACC_NONE;
            end else begin
                if (awaiting_read) begin
                    r.checked_address = word_address();
                    r.expected_value  = read_expectation();
                    if (read_data != r.expected_value) begin
                        r.mismatch = 1'b1;
                        if (error_total != '1) begin
                            error_total = error_total + 1'b1;
                        end
                    end
                end
                step_forward();
                issue_access(r);
            end
            r.error_count = error_total;
            if (r.access == ACC_WRITE) writes_seen++;
            if (r.access == ACC_READ) reads_seen++;
            if (r.access == ACC_FINISH) finishes_seen++;
            if (r.mismatch) mismatches_seen++;
            expected_accesses.push_back(r);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %h, actual %h", name, want, got);
                failures++;
            end
        endfunction

        // Check one accepted result transaction against the oldest prediction.
        function void check_result(t_access_result got);
            t_access_result want;
            if (expected_accesses.size() == 0) begin
                $error("result transaction with no prediction pending: %p", got);
                failures++;
                return;
            end
            want = expected_accesses.pop_front();
            compare_field("access", 32'(want.access), 32'(got.access));
            compare_field("address", want.address, got.address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("mismatch", 32'(want.mismatch), 32'(got.mismatch));
            compare_field("checked_address", want.checked_address, got.checked_address);
            compare_field("expected_value", want.expected_value, got.expected_value);
            compare_field("error_count", want.error_count, got.error_count);
            compare_field("passed", 32'(want.passed), 32'(got.passed));
        endfunction
    endclass

endpackage

[sim/testbench.sv]
// Self-checking testbench for the memory test sequencer unit.
`timescale 1ns / 100ps

module testbench;
    import mts_pkg::*;
    import mts_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 60;

    // One configuration setting of the random part.
    typedef struct {
        logic [31:0] base;
        logic [31:0] words;
        logic        repeat_on;
        int unsigned budget;
        int unsigned corrupt_pct;
    } t_test_setting;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mts_req_if req_ch ();
    mts_rsp_if rsp_ch ();

    mts_scoreboard sb = new();

    int unsigned cycle_count;
    logic        calm;
    logic        hold_done;
    int unsigned settings_run;

    memory_test_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check every accepted result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result('{rsp_ch.access, rsp_ch.address, rsp_ch.write_data,
                              rsp_ch.mismatch, rsp_ch.checked_address,
                              rsp_ch.expected_value, rsp_ch.error_count, rsp_ch.passed});
        end
    end

    // Receiver: random stalls, plus one long hold-off while requests keep coming.
    initial begin
        int unsigned stall_left;
        int unsigned pick;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end else if (!hold_done && sb.accepted >= 300) begin
                hold_done    = 1'b1;
                stall_left   = LONG_HOLD - 1;
                rsp_ch.ready = 1'b0;
            end else if (calm || !i_rst_n) begin
                rsp_ch.ready = i_rst_n;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    rsp_ch.ready = 1'b1;
                end else begin
                    stall_left   = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(7, 19);
                    rsp_ch.ready = 1'b0;
                end
            end
        end
    end

    // Offer one request transaction and wait until it is taken.
    task automatic send_request(input logic op, input logic [WORD_W-1:0] read_data);
        req_ch.valid     = 1'b1;
        req_ch.op        = op;
        req_ch.read_data = read_data;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, read_data);
        @(negedge i_clk);
        req_ch.valid     = 1'b0;
    endtask

    // Sender idle time between transactions: mostly none, sometimes long.
    task automatic sender_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (!calm) begin
            if (pick >= 95) gap = $urandom_range(8, 25);
            else if (pick >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_register(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(index, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [31:0] base, input logic [31:0] words,
                             input logic repeat_on);
        write_register(REG_BASE_ADDRESS, base);
        write_register(REG_WORD_COUNT, words);
        write_register(REG_CONTINUOUS, {31'd0, repeat_on});
    endtask

    // Wait until every predicted result has come back, then let the block settle.
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Mostly well-formed test runs with correct read data, plus aborts,
    // corrupted reads and stray advances after the test has finished.
    task automatic run_setting(input t_test_setting s);
        int unsigned spent;
        int unsigned pick;
        logic [WORD_W-1:0] data;
        spent = 0;
        while (spent < s.budget) begin
            pick = $urandom_range(0, 99);
            if (!sb.running()) begin
                if (pick < 20) begin
                    send_request(OP_ADVANCE, $urandom);
                end else begin
                    send_request(OP_START, $urandom);
                    spent++;
                end
            end else if (pick < 2) begin
                send_request(OP_START, $urandom);
                spent++;
            end else begin
                data = $urandom;
                if (sb.awaiting_read) begin
                    data = sb.read_expectation();
                    if ($urandom_range(0, 99) < s.corrupt_pct) begin
                        data = (pick < 50) ? data ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
                    end
                end
                send_request(OP_ADVANCE, data);
                spent++;
            end
            sender_gap();
        end
    endtask

    initial begin
        t_test_setting plan[8];
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_START;
        req_ch.read_data = '0;
        cycle_count      = 0;
        calm             = 1'b1;
        hold_done        = 1'b0;
        settings_run     = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: advance while idle, empty region in both modes.
        send_request(OP_ADVANCE, 32'hFFFF_FFFF);
        wait_drained();
        configure(32'h0, 32'h0, 1'b0);
        send_request(OP_START, 32'h0);
        send_request(OP_ADVANCE, 32'h0);
        wait_drained();
        configure(32'h0, 32'h0, 1'b1);
        send_request(OP_START, 32'hFFFF_FFFF);
        wait_drained();

        // Directed: unaligned top-of-memory base, extreme read data, aborts.
        configure(32'hFFFF_FFFF, 32'd3, 1'b0);
        send_request(OP_START, 32'h0);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_ADVANCE, 32'hFFFF_FFFF);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_START, 32'h0);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_START, 32'h1);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_ADVANCE, 32'h1);
        send_request(OP_ADVANCE, 32'h0);
        send_request(OP_ADVANCE, 32'h2);
        wait_drained();

        // Random settings; odd entries run without idle gaps on either side.
        plan[0] = '{32'h0000_1000, 32'd1, 1'b0, 90, 5};
        plan[1] = '{32'hFFFF_FFFF, 32'd2, 1'b0, 150, 4};
        plan[2] = '{$urandom, 32'd1, 1'b1, 100, 1};
        plan[3] = '{32'h0, 32'h4000_0000, 1'b1, 40, 5};
        plan[4] = '{$urandom, 32'd3, 1'b0, 120, 3};
        plan[5] = '{$urandom, 32'd0, 1'b1, 10, 0};
        plan[6] = '{$urandom, 32'd2, 1'b1, 100, 2};
        plan[7] = '{32'hFFFF_FFF0, 32'd5, 1'b0, 40, 10};
        foreach (plan[i]) begin
            calm = (i % 2) == 1;
            configure(plan[i].base, plan[i].words, plan[i].repeat_on);
            run_setting(plan[i]);
            wait_drained();
            settings_run++;
        end

        calm = 1'b1;
        wait_drained();
        $display("Covered %0d request transactions over %0d random settings plus directed cases.",
                 sb.accepted, settings_run);
        $display("Predicted %0d writes, %0d reads, %0d finishes and %0d flagged mismatches.",
                 sb.writes_seen, sb.reads_seen, sb.finishes_seen, sb.mismatches_seen);
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
src/mts_pkg.sv
src/mts_if.sv
src/memory_test_sequencer_unit.sv
src/mts_checker.sv
sim/mts_tb_pkg.sv
sim/testbench.sv
